// ===== hdl/pxh_pkg.sv =====
`default_nettype none
package pxh_pkg;

	// Table size used when the top level is not overridden
	localparam int TRACKED_PAGES_DEF = 4096;

	// Page data geometry
	localparam int LANE_W = 64;
	localparam int LANES  = 4;
	localparam int HASH_W = LANE_W * LANES;
	localparam int PAGE_W = 20;
	localparam int OP_W   = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
	localparam logic [OP_W-1:0] OP_TEST   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// One beat of page data with its operation
	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [PAGE_W-1:0] page_number;
		logic [LANE_W-1:0] lane_word0;
		logic [LANE_W-1:0] lane_word1;
		logic [LANE_W-1:0] lane_word2;
		logic [LANE_W-1:0] lane_word3;
		logic              last_beat;
	} item_t;

	// Completion report of one operation
	typedef struct packed {
		logic [OP_W-1:0]   done_opcode;
		logic [PAGE_W-1:0] done_page;
		logic              page_tracked;
		logic              page_modified;
		logic              out_of_range;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/page_xor_hash_change_tracker.sv =====
`default_nettype none
// Page change tracker: each page streams in as beats of four 64-bit lanes that are
// XOR-folded into a 256-bit hash; the beat with last_beat set completes a record,
// test or query on page_number and yields one result (opcode 3 yields none). Beats
// without last_beat, and the final beat of opcode 3, are taken one per cycle. The
// final beat of a record, test or query first reads the page's row from the tag
// memory (one row per page: valid bit and 256-bit tag, single read and single write
// port); the compare state then compares, writes back where the operation stores,
// and loads the result register; result backpressure holds the block in that state.
// After reset the block clears the valid bits of the tag memory, one row per cycle,
// and accepts no item until every row is cleared. Pages at or above TRACKED_PAGES are
// flagged out of range and never stored.
module page_xor_hash_change_tracker
	import pxh_pkg::*;
#(
	parameter int TRACKED_PAGES = TRACKED_PAGES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	localparam int AW = (TRACKED_PAGES > 1) ? $clog2(TRACKED_PAGES) : 1;
	localparam int ROW_W = HASH_W + 1;
	localparam logic [AW-1:0] LAST_ROW = AW'(TRACKED_PAGES - 1);
	localparam logic [PAGE_W:0] PAGE_LIMIT = (PAGE_W + 1)'(TRACKED_PAGES);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_RUN   = 3'b010,
		ST_CMP   = 3'b100
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_addr_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] lanes;
	logic              accept;
	logic              finish;

	logic [OP_W-1:0]   op_s1;
	logic [PAGE_W-1:0] page_s1;
	logic              inrange_s1;
	logic [HASH_W-1:0] hash_s1;

	logic              rd_en;
	logic [ROW_W-1:0]  rd_row;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [ROW_W-1:0]  wr_data;

	logic              tracked;
	logic              differ;
	logic              modified;
	logic              store;
	logic              complete;

	logic              out_valid_q;
	result_t           out_q;

	assign lanes = {item.lane_word3, item.lane_word2, item.lane_word1, item.lane_word0};
	assign item_ready = (state_q == ST_RUN);
	assign accept = item_valid && item_ready;
	assign finish = accept && item.last_beat && (item.opcode != OP_UNUSED);

	// Fold lanes into the running hash; clear it on the final beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			if (item.last_beat) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q ^ lanes;
			end
		end
	end

	// Capture the completed operation for the compare cycle
	always_ff @(posedge clk) begin
		if (finish) begin
			op_s1      <= item.opcode;
			page_s1    <= item.page_number;
			inrange_s1 <= ({1'b0, item.page_number} < PAGE_LIMIT);
			hash_s1    <= acc_q ^ lanes;
		end
	end

	// Compare against the stored row
	assign rd_en    = finish;
	assign tracked  = inrange_s1 && rd_row[HASH_W];
	assign differ   = (rd_row[HASH_W-1:0] != hash_s1);
	assign modified = (op_s1 == OP_TEST) && (!tracked || differ);
	assign complete = (state_q == ST_CMP) && (!out_valid_q || result_ready);
	assign store    = ((op_s1 == OP_RECORD) && inrange_s1)
		|| ((op_s1 == OP_TEST) && tracked && differ);

	// Write port: clearing sweep, else write-back of the new tag
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_CMP: begin
				wr_en   = complete && store;
				wr_addr = page_s1[AW-1:0];
				wr_data = {1'b1, hash_s1};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	pxh_ram #(
		.WIDTH(ROW_W),
		.DEPTH(TRACKED_PAGES)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(item.page_number[AW-1:0]),
		.rd_data(rd_row)
	);

	// Sequence: clear sweep, stream beats, compare and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == LAST_ROW) begin
						state_q <= ST_RUN;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (complete) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Result register: load on completion, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (complete) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			out_q.done_opcode   <= op_s1;
			out_q.done_page     <= page_s1;
			out_q.page_tracked  <= tracked;
			out_q.page_modified <= modified;
			out_q.out_of_range  <= !inrange_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

// ===== hdl/pxh_ram.sv =====
`default_nettype none
module pxh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire
